FILE: design/dtd_pkg.sv
// dtd_pkg: shared constants, register map and request types of the double talk detector
// no dependencies; imported by every module of the block
`default_nettype none

package dtd_pkg;

  localparam int unsigned NUM_BANDS = 8;
  localparam int unsigned MEAN_LEN  = 16;
  localparam int unsigned MIN_LEN   = 32;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned PROD_W      = 48;
  localparam int unsigned ALPHA_W     = 15;
  localparam int unsigned FACTOR_W    = 16;
  localparam int unsigned FACTOR_FRAC = 8;
  localparam int unsigned HANG_W      = 8;
  localparam int unsigned FRAME_CNT_W = 10;

  localparam int unsigned BAND_CNT_W  = $clog2(NUM_BANDS + 1);
  localparam int unsigned MEAN_AW     = (MEAN_LEN > 1) ? $clog2(MEAN_LEN) : 1;
  localparam int unsigned MEAN_FILL_W = $clog2(MEAN_LEN + 1);
  localparam int unsigned MEAN_SUM_W  = DATA_W + $clog2(MEAN_LEN);
  localparam int unsigned MIN_AW      = (MIN_LEN > 1) ? $clog2(MIN_LEN) : 1;
  localparam int unsigned MIN_CNT_W   = $clog2(MIN_LEN + 1);

  // register map
  localparam int unsigned NUM_REGS  = 5;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_ALPHA    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FACTOR   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_FLOOR    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_HANGOVER = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_STARTUP  = REG_IDX_W'(4);

  localparam logic [ALPHA_W-1:0]     RST_ALPHA    = ALPHA_W'(29491);
  localparam logic [FACTOR_W-1:0]    RST_FACTOR   = FACTOR_W'(512);
  localparam logic [DATA_W-1:0]      RST_FLOOR    = DATA_W'(1024);
  localparam logic [HANG_W-1:0]      RST_HANGOVER = HANG_W'(10);
  localparam logic [FRAME_CNT_W-1:0] RST_STARTUP  = FRAME_CNT_W'(100);

  // talk status codes
  localparam logic [1:0] TALK_FAR_END  = 2'd0;
  localparam logic [1:0] TALK_DOUBLE   = 2'd1;
  localparam logic [1:0] TALK_NEAR_END = 2'd2;

  typedef struct packed {
    logic [ALPHA_W-1:0]     smoothing_alpha;
    logic [FACTOR_W-1:0]    threshold_factor;
    logic [DATA_W-1:0]      threshold_floor;
    logic [HANG_W-1:0]      hangover_frames;
    logic [FRAME_CNT_W-1:0] startup_frames;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] bin_power;
    logic [DATA_W-1:0] bin_noise;
    logic              band_end;
    logic              far_end_active;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        talk_status;
    logic [DATA_W-1:0] smoothed_energy;
    logic [DATA_W-1:0] detect_threshold;
  } out_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] avg;
    logic              far_end_active;
  } frame_t;

endpackage

`default_nettype wire

FILE: design/double_talk_detector.sv
// double_talk_detector: top level of the residual energy double talk detector
// depends on dtd_pkg, dtd_regs, dtd_accum and dtd_frame
//
// Input channel: one request per frequency bin (power, noise, band end mark and
// far end flag), accepted when in_valid_i is high and in_stall_o is low.
// Bins are taken one per cycle while in_stall_o is low. The bin that closes the
// last band of a frame starts the frame work; in_stall_o then stays high while
// that bin passes the band-close, difference and frame-average registers and the
// frame state machine runs, so a frame of N bins costs its N bins plus that work.
// Output channel: one response per frame (talk status, smoothed energy,
// threshold), held in an output register until out_stall_i is low. The
// response is registered in the last frame state, after a minimum-window scan
// once every window is full; the scan reads one window entry per cycle from its
// memory. A stalled response blocks only the next frame's result; bins keep
// flowing until the next frame closes.
// Configuration: APB-style port, registers at byte offsets 0, 4, 8, 12, 16;
// write only while no frame is in progress. pready is always high.
// Reset: rst_ni clears all accumulators, windows (through fill counts, no
// clearing pass), counters and the output valid flag, and loads the register defaults.
`default_nettype none

module double_talk_detector import dtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_req_t            in_req_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_rsp_t           out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t   cfg;
  logic   frame_busy;
  logic   frame_vld;
  frame_t frame;

  dtd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dtd_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_req_i     (in_req_i),
    .in_stall_o   (in_stall_o),
    .frame_busy_i (frame_busy),
    .frame_vld_o  (frame_vld),
    .frame_o      (frame)
  );

  dtd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .frame_vld_i (frame_vld),
    .frame_i     (frame),
    .busy_o      (frame_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

FILE: design/dtd_regs.sv
// dtd_regs: APB-style configuration registers
// depends on dtd_pkg
`default_nettype none

module dtd_regs import dtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ALPHA:    cfg_d.smoothing_alpha  = pwdata[ALPHA_W-1:0];
        REG_FACTOR:   cfg_d.threshold_factor = pwdata[FACTOR_W-1:0];
        REG_FLOOR:    cfg_d.threshold_floor  = pwdata[DATA_W-1:0];
        REG_HANGOVER: cfg_d.hangover_frames  = pwdata[HANG_W-1:0];
        REG_STARTUP:  cfg_d.startup_frames   = pwdata[FRAME_CNT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALPHA:    prdata = PDATA_W'(cfg_q.smoothing_alpha);
      REG_FACTOR:   prdata = PDATA_W'(cfg_q.threshold_factor);
      REG_FLOOR:    prdata = PDATA_W'(cfg_q.threshold_floor);
      REG_HANGOVER: prdata = PDATA_W'(cfg_q.hangover_frames);
      REG_STARTUP:  prdata = PDATA_W'(cfg_q.startup_frames);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{smoothing_alpha:  RST_ALPHA,
                 threshold_factor: RST_FACTOR,
                 threshold_floor:  RST_FLOOR,
                 hangover_frames:  RST_HANGOVER,
                 startup_frames:   RST_STARTUP};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/dtd_accum.sv
// dtd_accum: band and frame energy accumulation pipeline
// depends on dtd_pkg; hands one frame average at a time to dtd_frame
`default_nettype none

module dtd_accum import dtd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  in_req_t in_req_i,
  output logic    in_stall_o,
  input  logic    frame_busy_i,
  output logic    frame_vld_o,
  output frame_t  frame_o
);

  logic                  in_acc;
  logic [ACC_W-1:0]      pw_acc_q, nz_acc_q;
  logic [ACC_W:0]        pw_sum, nz_sum;
  logic [ACC_W-1:0]      pw_sat, nz_sat;
  logic [BAND_CNT_W-1:0] band_cnt_q;
  logic                  band_last;

  // stage 1: closed band sums
  logic                  close_vld_q, close_last_q, close_far_q;
  logic [ACC_W-1:0]      close_pw_q, close_nz_q;
  // stage 2: clipped band difference
  logic [ACC_W:0]        diff_full;
  logic [ACC_W-1:0]      diff, diff_q;
  logic                  diff_vld_q, diff_last_q, diff_far_q;
  // stage 3: frame energy
  logic [ACC_W-1:0]      frame_acc_q, frame_total_q;
  logic [ACC_W:0]        fa_sum;
  logic [ACC_W-1:0]      fa_sat, total_div;
  logic                  frame_vld_q, frame_far_q;

  assign in_stall_o = frame_busy_i | (close_vld_q & close_last_q) | diff_last_q | frame_vld_q;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign pw_sum    = {1'b0, pw_acc_q} + (ACC_W+1)'(in_req_i.bin_power);
  assign nz_sum    = {1'b0, nz_acc_q} + (ACC_W+1)'(in_req_i.bin_noise);
  assign pw_sat    = pw_sum[ACC_W] ? '1 : pw_sum[ACC_W-1:0];
  assign nz_sat    = nz_sum[ACC_W] ? '1 : nz_sum[ACC_W-1:0];
  assign band_last = (band_cnt_q == BAND_CNT_W'(NUM_BANDS - 1));

  assign diff_full = {1'b0, close_pw_q} - {1'b0, close_nz_q};
  assign diff      = diff_full[ACC_W] ? '0 : diff_full[ACC_W-1:0];

  assign fa_sum    = {1'b0, frame_acc_q} + {1'b0, diff_q};
  assign fa_sat    = fa_sum[ACC_W] ? '1 : fa_sum[ACC_W-1:0];

  assign total_div              = frame_total_q / ACC_W'(NUM_BANDS);
  assign frame_vld_o            = frame_vld_q;
  assign frame_o.avg            = (|total_div[ACC_W-1:DATA_W]) ? '1 : total_div[DATA_W-1:0];
  assign frame_o.far_end_active = frame_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_acc_q     <= '0;
      nz_acc_q     <= '0;
      band_cnt_q   <= '0;
      close_vld_q  <= 1'b0;
      close_last_q <= 1'b0;
      diff_vld_q   <= 1'b0;
      diff_last_q  <= 1'b0;
      frame_acc_q  <= '0;
      frame_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_req_i.band_end) begin
          pw_acc_q   <= '0;
          nz_acc_q   <= '0;
          band_cnt_q <= band_last ? '0 : band_cnt_q + 1'b1;
        end else begin
          pw_acc_q <= pw_sat;
          nz_acc_q <= nz_sat;
        end
      end
      close_vld_q  <= in_acc & in_req_i.band_end;
      close_last_q <= band_last;
      diff_vld_q   <= close_vld_q;
      diff_last_q  <= close_vld_q & close_last_q;
      if (diff_vld_q) begin
        frame_acc_q <= diff_last_q ? '0 : fa_sat;
      end
      frame_vld_q <= diff_vld_q & diff_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc & in_req_i.band_end) begin
      close_pw_q  <= pw_sat;
      close_nz_q  <= nz_sat;
      close_far_q <= in_req_i.far_end_active;
    end
    if (close_vld_q) begin
      diff_q     <= diff;
      diff_far_q <= close_far_q;
    end
    if (diff_vld_q & diff_last_q) begin
      frame_total_q <= fa_sat;
      frame_far_q   <= diff_far_q;
    end
  end

endmodule

`default_nettype wire

FILE: design/dtd_frame.sv
// dtd_frame: per-frame smoothing, mean and minimum windows, threshold and talk status
// depends on dtd_pkg; window state lives in two synchronous memories
`default_nettype none

module dtd_frame import dtd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     frame_vld_i,
  input  frame_t   frame_i,
  output logic     busy_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL2   = 9'b000000010,
    ST_SMOOTH = 9'b000000100,
    ST_MEAN   = 9'b000001000,
    ST_MINW   = 9'b000010000,
    ST_SCAN   = 9'b000100000,
    ST_MULT   = 9'b001000000,
    ST_LIMIT  = 9'b010000000,
    ST_STAT   = 9'b100000000
  } frame_state_e;

  frame_state_e state_q, state_d;

  logic [DATA_W-1:0]      avg_q, avg_d;
  logic                   far_q, far_d;
  logic [PROD_W-1:0]      prod_q, prod_d, psum_q, psum_d, sm_sum;
  logic [DATA_W-1:0]      smoothed_q, smoothed_d;
  logic [MEAN_AW-1:0]     mean_head_q, mean_head_d;
  logic [MEAN_FILL_W-1:0] mean_fill_q, mean_fill_d;
  logic [MEAN_SUM_W-1:0]  mean_sum_q, mean_sum_d, mean_old;
  logic [DATA_W-1:0]      mean_val;
  logic [MIN_AW-1:0]      min_head_q, min_head_d;
  logic [MIN_CNT_W-1:0]   min_fill_q, min_fill_d;
  logic [MIN_CNT_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic                   scan_rd_q, scan_rd_d;
  logic [DATA_W-1:0]      min_q, min_d;
  logic [DATA_W-1:0]      thr_q, thr_d, thr_sat;
  logic [HANG_W-1:0]      hang_q, hang_d;
  logic [FRAME_CNT_W-1:0] frame_cnt_q, frame_cnt_d;
  logic                   out_valid_q, out_valid_d;
  out_rsp_t               out_rsp_q, out_rsp_d;

  logic [FACTOR_W-1:0]    mul_a;
  logic [DATA_W-1:0]      mul_b;
  logic [PROD_W-1:0]      mul_p;

  logic                   mean_re, mean_we, min_re, min_we;
  logic [DATA_W-1:0]      mean_rd_q, min_rd_q;
  logic [DATA_W-1:0]      mean_mem [MEAN_LEN];
  logic [DATA_W-1:0]      min_mem  [MIN_LEN];
  logic                   out_free;

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // shared multiplier
  always_comb begin
    priority if (state_q == ST_MUL2) begin
      mul_a = FACTOR_W'((ALPHA_W+1)'(1) << ALPHA_W) - FACTOR_W'(cfg_i.smoothing_alpha);
      mul_b = avg_q;
    end else if (state_q == ST_MULT) begin
      mul_a = cfg_i.threshold_factor;
      mul_b = min_q;
    end else begin
      mul_a = FACTOR_W'(cfg_i.smoothing_alpha);
      mul_b = smoothed_q;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign sm_sum   = psum_q + prod_q + (PROD_W'(1) << (ALPHA_W - 1));
  assign mean_old = (mean_fill_q == MEAN_FILL_W'(MEAN_LEN)) ? MEAN_SUM_W'(mean_rd_q) : '0;
  assign mean_val = DATA_W'(mean_sum_q / MEAN_SUM_W'(MEAN_LEN));
  assign thr_sat  = (|prod_q[PROD_W-1:DATA_W+FACTOR_FRAC]) ? '1
                                                           : prod_q[FACTOR_FRAC +: DATA_W];

  assign mean_re = (state_q == ST_IDLE) & frame_vld_i;
  assign mean_we = (state_q == ST_MEAN);
  assign min_we  = (state_q == ST_MINW);
  assign min_re  = (state_q == ST_SCAN) & (scan_cnt_q != MIN_CNT_W'(MIN_LEN));

  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[mean_head_q] <= smoothed_q;
    end
    if (mean_re) begin
      mean_rd_q <= mean_mem[mean_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (min_we) begin
      min_mem[min_head_q] <= mean_val;
    end
    if (min_re) begin
      min_rd_q <= min_mem[scan_cnt_q[MIN_AW-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    avg_d       = avg_q;
    far_d       = far_q;
    prod_d      = prod_q;
    psum_d      = psum_q;
    smoothed_d  = smoothed_q;
    mean_head_d = mean_head_q;
    mean_fill_d = mean_fill_q;
    mean_sum_d  = mean_sum_q;
    min_head_d  = min_head_q;
    min_fill_d  = min_fill_q;
    scan_cnt_d  = scan_cnt_q;
    scan_rd_d   = scan_rd_q;
    min_d       = min_q;
    thr_d       = thr_q;
    hang_d      = hang_q;
    frame_cnt_d = frame_cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_rsp_d   = out_rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (frame_vld_i) begin
          avg_d   = frame_i.avg;
          far_d   = frame_i.far_end_active;
          prod_d  = mul_p;
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        psum_d  = prod_q;
        prod_d  = mul_p;
        state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        smoothed_d = sm_sum[ALPHA_W +: DATA_W];
        state_d    = ST_MEAN;
      end
      ST_MEAN: begin
        mean_sum_d  = mean_sum_q - mean_old + MEAN_SUM_W'(smoothed_q);
        mean_head_d = (mean_head_q == MEAN_AW'(MEAN_LEN - 1)) ? '0 : mean_head_q + 1'b1;
        if (mean_fill_q != MEAN_FILL_W'(MEAN_LEN)) begin
          mean_fill_d = mean_fill_q + 1'b1;
        end
        state_d = ST_MINW;
      end
      ST_MINW: begin
        min_head_d = (min_head_q == MIN_AW'(MIN_LEN - 1)) ? '0 : min_head_q + 1'b1;
        if (min_fill_q != MIN_CNT_W'(MIN_LEN)) begin
          min_fill_d = min_fill_q + 1'b1;
        end
        scan_cnt_d = '0;
        scan_rd_d  = 1'b0;
        // an unwritten entry counts as zero, so the minimum is zero
        if (min_fill_q >= MIN_CNT_W'(MIN_LEN - 1)) begin
          min_d   = '1;
          state_d = ST_SCAN;
        end else begin
          min_d   = '0;
          state_d = ST_MULT;
        end
      end
      ST_SCAN: begin
        scan_rd_d = min_re;
        if (min_re) begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (scan_rd_q && (min_rd_q < min_q)) begin
          min_d = min_rd_q;
        end
        if (!min_re && !scan_rd_q) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        prod_d  = mul_p;
        state_d = ST_LIMIT;
      end
      ST_LIMIT: begin
        thr_d   = (thr_sat < cfg_i.threshold_floor) ? cfg_i.threshold_floor : thr_sat;
        state_d = ST_STAT;
      end
      ST_STAT: begin
        if (out_free) begin
          out_rsp_d.smoothed_energy  = smoothed_q;
          out_rsp_d.detect_threshold = thr_q;
          if (frame_cnt_q < cfg_i.startup_frames) begin
            frame_cnt_d           = frame_cnt_q + 1'b1;
            out_rsp_d.talk_status = TALK_FAR_END;
          end else begin
            if (smoothed_q > thr_q) begin
              hang_d = cfg_i.hangover_frames;
            end else if (hang_q != '0) begin
              hang_d = hang_q - 1'b1;
            end
            if ((hang_d != '0) && far_q) begin
              out_rsp_d.talk_status = TALK_DOUBLE;
            end else if (!far_q) begin
              out_rsp_d.talk_status = TALK_NEAR_END;
            end else begin
              out_rsp_d.talk_status = TALK_FAR_END;
            end
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      smoothed_q  <= '0;
      mean_head_q <= '0;
      mean_fill_q <= '0;
      mean_sum_q  <= '0;
      min_head_q  <= '0;
      min_fill_q  <= '0;
      scan_cnt_q  <= '0;
      scan_rd_q   <= 1'b0;
      hang_q      <= '0;
      frame_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      smoothed_q  <= smoothed_d;
      mean_head_q <= mean_head_d;
      mean_fill_q <= mean_fill_d;
      mean_sum_q  <= mean_sum_d;
      min_head_q  <= min_head_d;
      min_fill_q  <= min_fill_d;
      scan_cnt_q  <= scan_cnt_d;
      scan_rd_q   <= scan_rd_d;
      hang_q      <= hang_d;
      frame_cnt_q <= frame_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q     <= avg_d;
    far_q     <= far_d;
    prod_q    <= prod_d;
    psum_q    <= psum_d;
    min_q     <= min_d;
    thr_q     <= thr_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

`default_nettype wire

FILE: design/dtd_checker.sv
// dtd_checker: port-level assertions for double_talk_detector
// depends on dtd_pkg; bound to the top level at the end of this file
`default_nettype none

module dtd_checker import dtd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("stalled response changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.talk_status == TALK_FAR_END ||
                     out_rsp_o.talk_status == TALK_DOUBLE ||
                     out_rsp_o.talk_status == TALK_NEAR_END))
    else $error("bad talk status code");

  // a new response is only produced while the bin input is held off
  a_rsp_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("response produced outside frame work");

endmodule

bind double_talk_detector dtd_checker u_dtd_checker (.*);

`default_nettype wire

FILE: sim/dtd_result_check.sv
`timescale 1ns / 100ps
// dtd_result_check: watches the bin, result and register ports of the double talk detector,
// predicts one talk status report per frame and compares it field by field
// depends on dtd_pkg for request types, register indexes and reset values
module dtd_result_check import dtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_req_t            in_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_rsp_t           out_rsp_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        reports_o
);

  localparam logic [63:0] U32_SAT = 64'hFFFF_FFFF;

  cfg_t                   cfg;
  logic [ACC_W-1:0]       power_sum;
  logic [ACC_W-1:0]       noise_sum;
  logic [ACC_W-1:0]       energy_sum;
  int unsigned            bands_closed;
  logic [DATA_W-1:0]      smoothed;
  logic [DATA_W-1:0]      mean_hist [MEAN_LEN];
  logic [MEAN_SUM_W-1:0]  mean_total;
  logic [DATA_W-1:0]      min_hist [MIN_LEN];
  int unsigned            mean_pos;
  int unsigned            min_pos;
  logic [HANG_W-1:0]      hang_left;
  logic [FRAME_CNT_W-1:0] frames_seen;
  out_rsp_t               frame_reports_q [$];
  out_rsp_t               oldest_report;
  int unsigned            slot;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  task automatic accumulate_bin(input in_req_t r);
    logic [63:0]       avg;
    logic [63:0]       blend;
    logic [63:0]       thr;
    logic [DATA_W-1:0] mean;
    logic [DATA_W-1:0] minv;
    logic [1:0]        status;
    int                i;
    power_sum = sat_add(power_sum, ACC_W'(r.bin_power));
    noise_sum = sat_add(noise_sum, ACC_W'(r.bin_noise));
    if (!r.band_end) return;
    if (power_sum > noise_sum) energy_sum = sat_add(energy_sum, power_sum - noise_sum);
    power_sum = '0;
    noise_sum = '0;
    bands_closed++;
    if (bands_closed < NUM_BANDS) return;

    avg = 64'(energy_sum) / NUM_BANDS;
    if (avg > U32_SAT) avg = U32_SAT;
    energy_sum = '0;
    bands_closed = 0;

    blend = 64'(cfg.smoothing_alpha) * 64'(smoothed)
          + (64'd32768 - 64'(cfg.smoothing_alpha)) * avg + 64'd16384;
    smoothed = DATA_W'(blend >> 15);

    mean_total = mean_total - MEAN_SUM_W'(mean_hist[mean_pos]) + MEAN_SUM_W'(smoothed);
    mean_hist[mean_pos] = smoothed;
    mean_pos = (mean_pos + 1) % MEAN_LEN;
    mean = DATA_W'(mean_total / MEAN_LEN);

    min_hist[min_pos] = mean;
    min_pos = (min_pos + 1) % MIN_LEN;
    minv = min_hist[0];
    for (i = 1; i < MIN_LEN; i++) begin
      if (min_hist[i] < minv) minv = min_hist[i];
    end

    thr = (64'(cfg.threshold_factor) * 64'(minv)) >> FACTOR_FRAC;
    if (thr > U32_SAT) thr = U32_SAT;
    if (thr < 64'(cfg.threshold_floor)) thr = 64'(cfg.threshold_floor);

    if (frames_seen < cfg.startup_frames) begin
      frames_seen++;
      status = TALK_FAR_END;
    end else begin
      if (64'(smoothed) > thr) begin
        hang_left = cfg.hangover_frames;
      end else if (hang_left != 0) begin
        hang_left--;
      end
      if (hang_left != 0 && r.far_end_active) begin
        status = TALK_DOUBLE;
      end else if (!r.far_end_active) begin
        status = TALK_NEAR_END;
      end else begin
        status = TALK_FAR_END;
      end
    end

    frame_reports_q.push_back('{talk_status: status, smoothed_energy: smoothed,
                                detect_threshold: thr[DATA_W-1:0]});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{smoothing_alpha: RST_ALPHA, threshold_factor: RST_FACTOR,
              threshold_floor: RST_FLOOR, hangover_frames: RST_HANGOVER,
              startup_frames: RST_STARTUP};
      power_sum = '0;
      noise_sum = '0;
      energy_sum = '0;
      bands_closed = 0;
      smoothed = '0;
      mean_total = '0;
      mean_pos = 0;
      min_pos = 0;
      hang_left = '0;
      frames_seen = '0;
      for (slot = 0; slot < MEAN_LEN; slot++) mean_hist[slot] = '0;
      for (slot = 0; slot < MIN_LEN; slot++) min_hist[slot] = '0;
      frame_reports_q.delete();
      mismatches_o <= 0;
      pending_o <= 0;
      reports_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_reports_q.size() == 0) begin
          $display("%0t: unexpected frame result %p", $time, out_rsp_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          oldest_report = frame_reports_q.pop_front();
          if (out_rsp_i !== oldest_report) begin
            mismatches_o <= mismatches_o + 1;
            if (out_rsp_i.talk_status !== oldest_report.talk_status)
              $display("%0t: talk_status expected %0d, got %0d", $time,
                       oldest_report.talk_status, out_rsp_i.talk_status);
            if (out_rsp_i.smoothed_energy !== oldest_report.smoothed_energy)
              $display("%0t: smoothed_energy expected %0d, got %0d", $time,
                       oldest_report.smoothed_energy, out_rsp_i.smoothed_energy);
            if (out_rsp_i.detect_threshold !== oldest_report.detect_threshold)
              $display("%0t: detect_threshold expected %0d, got %0d", $time,
                       oldest_report.detect_threshold, out_rsp_i.detect_threshold);
          end
          reports_o <= reports_o + 1;
        end
      end

      if (in_valid_i && !in_stall_i) accumulate_bin(in_req_i);

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_ALPHA:    cfg.smoothing_alpha  = pwdata_i[ALPHA_W-1:0];
          REG_FACTOR:   cfg.threshold_factor = pwdata_i[FACTOR_W-1:0];
          REG_FLOOR:    cfg.threshold_floor  = pwdata_i[DATA_W-1:0];
          REG_HANGOVER: cfg.hangover_frames  = pwdata_i[HANG_W-1:0];
          REG_STARTUP:  cfg.startup_frames   = pwdata_i[FRAME_CNT_W-1:0];
          default: ;
        endcase
      end

      pending_o <= frame_reports_q.size();
    end
  end

endmodule

FILE: sim/double_talk_detector_tb.sv
`timescale 1ns / 100ps
// double_talk_detector_tb: drives bins, register writes and result stalls into the detector
// depends on dtd_pkg, double_talk_detector and dtd_result_check, which compares every frame result
module double_talk_detector_tb;
  import dtd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = MIN_LEN + 32;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned LONG_BAND    = 257;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(NUM_REGS);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  in_req_t            in_req_i = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_rsp_t           out_rsp_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned reports;
  int unsigned cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bins_sent = 0;
  int unsigned frames_sent = 0;

  cfg_t        plan [NUM_PHASES];
  idle_mode_e  plan_idle [NUM_PHASES];
  int unsigned plan_bins [NUM_PHASES];

  double_talk_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dtd_result_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_i    (out_rsp_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .reports_o    (reports)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding",
               $time, cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 62; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 62; end
      default:       begin gap_pct = 10; stall_pct = 10; end
    endcase
  endtask

  task automatic send_bin(input logic [DATA_W-1:0] power, input logic [DATA_W-1:0] noise,
                          input logic last, input logic far);
    in_req_t req;
    req = '{bin_power: power, bin_noise: noise, band_end: last, far_end_active: far};
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bins_sent++;
  endtask

  function automatic logic [DATA_W-1:0] draw_level(input bit loud);
    if ($urandom_range(9, 0) == 0) return $urandom();
    return $urandom() >> (loud ? $urandom_range(8, 4) : $urandom_range(24, 18));
  endfunction

  // long_band makes the first band full-scale for LONG_BAND bins so the accumulators clip
  task automatic send_frame(input bit loud, input bit far, input bit long_band);
    int unsigned       len;
    int unsigned       b;
    int unsigned       k;
    logic [DATA_W-1:0] power;
    logic [DATA_W-1:0] noise;
    for (b = 0; b < NUM_BANDS; b++) begin
      len = ($urandom_range(9, 0) != 0) ? 1 : $urandom_range(6, 2);
      if (long_band && b == 0) len = LONG_BAND;
      for (k = 1; k <= len; k++) begin
        power = (long_band && b == 0) ? '1 : draw_level(loud);
        noise = ($urandom_range(9, 0) == 0) ? $urandom() : $urandom() >> $urandom_range(26, 19);
        send_bin(power, noise, k == len,
                 (b == NUM_BANDS - 1 && k == len) ? far : 1'($urandom_range(1, 0)));
      end
    end
    frames_sent++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // unused upper data bits carry noise; the block keeps only the register width
  task automatic load_settings(input cfg_t c);
    logic [PDATA_W-1:0] junk;
    junk = $urandom();
    write_reg(REG_ALPHA, {junk[PDATA_W-1:ALPHA_W], c.smoothing_alpha});
    write_reg(REG_FACTOR, {junk[PDATA_W-1:FACTOR_W], c.threshold_factor});
    write_reg(REG_FLOOR, c.threshold_floor);
    write_reg(REG_HANGOVER, {junk[PDATA_W-1:HANG_W], c.hangover_frames});
    write_reg(REG_STARTUP, {junk[PDATA_W-1:FRAME_CNT_W], c.startup_frames});
    write_reg(REG_SPARE, $urandom());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned p;
    int unsigned b;
    int unsigned start;

    plan[0] = '{smoothing_alpha: 16384, threshold_factor: 512, threshold_floor: 1024,
                hangover_frames: 3, startup_frames: 0};
    plan[1] = '{smoothing_alpha: 0, threshold_factor: 256, threshold_floor: 0,
                hangover_frames: 0, startup_frames: 0};
    plan[2] = '{smoothing_alpha: 32767, threshold_factor: 65535, threshold_floor: 32'hFFFF_FFFF,
                hangover_frames: 255, startup_frames: 0};
    plan[3] = '{smoothing_alpha: 29491, threshold_factor: 1024, threshold_floor: 50000,
                hangover_frames: 255, startup_frames: 1023};
    plan[4] = '{smoothing_alpha: 8192, threshold_factor: 768, threshold_floor: 2048,
                hangover_frames: 6, startup_frames: 0};
    plan[5] = '{smoothing_alpha: ALPHA_W'($urandom()),
                threshold_factor: FACTOR_W'($urandom_range(1024, 256)),
                threshold_floor: $urandom_range(4096, 0),
                hangover_frames: HANG_W'($urandom_range(12, 1)),
                startup_frames: FRAME_CNT_W'($urandom_range(3, 0))};
    plan_idle = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};
    plan_bins = '{80, 80, 60, 30, 80, 80};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: start-up forces far end only, windows still empty
    set_idle(IDLE_NONE);
    send_bin('1, '0, 1'b0, 1'b1);
    for (b = 0; b < NUM_BANDS; b++) send_bin('1, '0, 1'b1, 1'b1);
    for (b = 0; b < NUM_BANDS; b++) send_bin('0, '1, 1'b1, 1'b0);
    for (b = 0; b < NUM_BANDS; b++) begin
      send_bin(b[0] ? 32'h5555_5555 : 32'hAAAA_AAAA, b[0] ? 32'hAAAA_AAAA : 32'h5555_5555,
               1'b1, b[0]);
    end
    frames_sent += 3;

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      load_settings(plan[p]);
      set_idle(plan_idle[p]);
      if (p == 2) send_frame(1'b1, 1'b1, 1'b1);
      start = bins_sent;
      while (bins_sent - start < plan_bins[p]) begin
        send_frame($urandom_range(9, 0) < 3, $urandom_range(3, 0) != 0, 1'b0);
      end
    end

    set_idle(IDLE_NONE);
    wait_idle();
    $display("%0d bins in %0d frames, %0d frame reports compared, %0d mismatches",
             bins_sent, frames_sent, reports, mismatches);
    $display("register settings: reset values plus %0d written sets", NUM_PHASES);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
